// File: hdl/assert_macros.svh
// Assertion macros shared by the allocator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge outside reset.
`define SBA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("allocator check failed");

// Check that a condition implies a consequence in the same cycle.
`define SBA_ASSERT_IMPL(name, clk, rst, cond, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("allocator check failed");

`else

`define SBA_ASSERT(name, clk, rst, prop)
`define SBA_ASSERT_IMPL(name, clk, rst, cond, cons)

`endif

`endif

// File: hdl/sba_pkg.sv
package sba_pkg;

   localparam int ADDR_W    = 24;
   localparam int SIZE_W    = 5;
   localparam int STAT_W    = 2;
   localparam int RESV_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_SIZE_CLASSES      = 32;
   localparam int DEF_ENTRIES_PER_FRAME = 64;
   localparam int DEF_FRAMES            = 64;
   localparam int DEF_CLASS_DEPTH       = 1024;

   localparam logic [ADDR_W-1:0] RESET_PART_START = 24'd1;
   localparam logic [ADDR_W-1:0] RESET_PART_END   = 24'hFFFFFF;
   localparam logic [RESV_W-1:0] RESET_RESERVE    = 16'd64;

   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OOM      = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_FRAME = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PART_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PART_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESERVE    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_POP_RD,
      ST_POP_DATA,
      ST_SPLIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic eval;
      logic free_push;
      logic take_rem;
      logic take_bump;
      logic oom;
      logic pop;
      logic pop_data;
      logic push_rem;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic rem_fit;
      logic bump_res_ok;
      logic class_found;
      logic bump_end_ok;
      logic split;
      logic rem_push;
      logic rsp_busy;
   } stat_type;

endpackage

// File: hdl/sba_ram.sv
module sba_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sba_ctrl.sv
`include "assert_macros.svh"

module sba_ctrl import sba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.is_free || stat.rem_fit || stat.bump_res_ok || !stat.class_found) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_POP_RD;
            end
         end
         ST_POP_RD: state_in = ST_POP_DATA;
         ST_POP_DATA: begin
            if (stat.split && stat.rem_push) state_in = ST_SPLIT;
            else state_in = ST_DONE;
         end
         ST_SPLIT: state_in = ST_DONE;
         ST_DONE: begin
            if (!stat.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EVAL: begin
            cmd.eval      = 1'b1;
            cmd.free_push = stat.is_free;
            cmd.take_rem  = !stat.is_free && stat.rem_fit;
            cmd.take_bump = !stat.is_free && !stat.rem_fit &&
                            (stat.bump_res_ok || (!stat.class_found && stat.bump_end_ok));
            cmd.oom       = !stat.is_free && !stat.rem_fit && !stat.bump_res_ok &&
                            !stat.class_found && !stat.bump_end_ok;
         end
         ST_POP_RD:   cmd.pop      = 1'b1;
         ST_POP_DATA: cmd.pop_data = 1'b1;
         ST_SPLIT:    cmd.push_rem = 1'b1;
         ST_DONE:     cmd.emit     = !stat.rsp_busy;
         default: ;
      endcase
   end

   `SBA_ASSERT_IMPL(a_accept_eval, clock, reset, req_valid && !req_stall, ##1 state_ff == ST_EVAL)
   `SBA_ASSERT_IMPL(a_pop_order, clock, reset, state_ff == ST_POP_DATA, $past(state_ff) == ST_POP_RD)
   `SBA_ASSERT_IMPL(a_emit_once, clock, reset, cmd.emit, ##1 state_ff == ST_IDLE)

endmodule

// File: hdl/sba_datapath.sv
`include "assert_macros.svh"

module sba_datapath import sba_pkg::*; #(
   parameter int SIZE_CLASSES      = DEF_SIZE_CLASSES,
   parameter int ENTRIES_PER_FRAME = DEF_ENTRIES_PER_FRAME,
   parameter int FRAMES            = DEF_FRAMES,
   parameter int CLASS_DEPTH       = DEF_CLASS_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_mode,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [ADDR_W-1:0]    req_block_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_granted_address,
   output logic [SIZE_W-1:0]    rsp_granted_size,
   output logic [STAT_W-1:0]    rsp_status,
   input  logic                 csr_valid,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata,
   input  cmd_type              cmd,
   output stat_type             stat
);

   localparam int CLS_W     = $clog2(SIZE_CLASSES);
   localparam int W         = (CLS_W > SIZE_W) ? CLS_W : SIZE_W;
   localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
   localparam int OFF_W     = (ENTRIES_PER_FRAME > 1) ? $clog2(ENTRIES_PER_FRAME) : 1;
   localparam int FR_W      = $clog2(FRAMES + 1);
   localparam int MEM_DEPTH = SIZE_CLASSES * CLASS_DEPTH;
   localparam int MA_W      = $clog2(MEM_DEPTH);
   localparam logic [MA_W-1:0]  CD_MA   = MA_W'(CLASS_DEPTH);
   localparam logic [OFF_W-1:0] OFF_TOP = OFF_W'(ENTRIES_PER_FRAME - 1);

   // configuration
   logic [ADDR_W-1:0] start_ff, start_in, end_ff, end_in;
   logic [RESV_W-1:0] resv_ff, resv_in;
   // request
   logic              mode_ff, mode_in;
   logic [SIZE_W-1:0] n_ff, n_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   // allocator state
   logic [ADDR_W-1:0] bump_ff, bump_in, rem_addr_ff, rem_addr_in;
   logic [W-1:0]      rem_size_ff, rem_size_in;
   logic [CNT_W-1:0]  cnt_ff [SIZE_CLASSES];
   logic [CNT_W-1:0]  cnt_in [SIZE_CLASSES];
   logic [OFF_W-1:0]  off_ff [SIZE_CLASSES];
   logic [OFF_W-1:0]  off_in [SIZE_CLASSES];
   logic [FR_W-1:0]   frames_ff, frames_in;
   logic [CLS_W-1:0]  found_ff, found_in;
   logic              rel_ff, rel_in;
   // result
   logic [ADDR_W-1:0] res_addr_ff, res_addr_in;
   logic [SIZE_W-1:0] res_size_ff, res_size_in;
   logic [STAT_W-1:0] res_stat_ff, res_stat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0] rsp_size_ff, rsp_size_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   logic              found_ok;
   logic [CLS_W-1:0]  found_idx;
   logic [W-1:0]      found_w, n_w, push_cls;
   logic [CLS_W-1:0]  sel;
   logic [CNT_W-1:0]  cnt_sel;
   logic [OFF_W-1:0]  off_sel, off_dec;
   logic              push_act, in_range, need_frame, push_write, push_fail;
   logic              new_rem, release_now;
   logic [ADDR_W:0]   bump_n_sum, bump_res_sum;
   logic [MA_W-1:0]   base_addr, wr_addr, rd_addr;
   logic [ADDR_W-1:0] rd_data, rem_src;

   assign n_w     = W'(n_ff);
   assign found_w = W'(found_ff);

   // lowest non-empty class at or above the request
   always_comb begin
      found_ok  = 1'b0;
      found_idx = '0;
      for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
         if (cnt_ff[c] != '0 && c >= int'(n_ff)) begin
            found_ok  = 1'b1;
            found_idx = CLS_W'(c);
         end
      end
   end

   assign bump_n_sum   = {1'b0, bump_ff} + (ADDR_W + 1)'(n_ff);
   assign bump_res_sum = {1'b0, bump_ff} + (ADDR_W + 1)'(resv_ff);

   assign stat.is_free     = mode_ff;
   assign stat.rem_fit     = rem_size_ff >= n_w;
   assign stat.bump_res_ok = bump_res_sum < {1'b0, end_ff};
   assign stat.class_found = found_ok;
   assign stat.bump_end_ok = bump_n_sum < {1'b0, end_ff};
   assign stat.split       = {1'b0, found_w} >= ({1'b0, n_w} + (W + 1)'(2));
   assign stat.rem_push    = rem_size_ff >= W'(2);
   assign stat.rsp_busy    = rsp_valid_ff && rsp_stall;

   assign push_act   = cmd.free_push || cmd.push_rem;
   assign push_cls   = cmd.push_rem ? rem_size_ff : n_w;
   assign in_range   = int'(push_cls) < SIZE_CLASSES;
   assign sel        = cmd.pop ? found_ff : push_cls[CLS_W-1:0];
   assign cnt_sel    = cnt_ff[sel];
   assign off_sel    = off_ff[sel];
   assign off_dec    = (off_sel == '0) ? OFF_TOP : off_sel - OFF_W'(1);
   assign need_frame = off_sel == '0;
   assign push_write = push_act && in_range && cnt_sel != CNT_W'(CLASS_DEPTH) &&
                       !(need_frame && frames_ff == '0);
   assign push_fail  = push_act && in_range && !push_write;

   assign base_addr = MA_W'(sel) * CD_MA;
   assign wr_addr   = base_addr + MA_W'(cnt_sel);
   assign rd_addr   = base_addr + MA_W'(cnt_sel - CNT_W'(1));

   assign new_rem     = (cmd.pop_data && stat.split && !stat.rem_push) || cmd.push_rem;
   assign release_now = (cmd.pop_data && !(stat.split && stat.rem_push)) || cmd.push_rem;
   assign rem_src     = cmd.push_rem ? res_addr_ff : rd_data;

   sba_ram #(
      .WIDTH (ADDR_W),
      .DEPTH (MEM_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (push_write),
      .wr_addr (wr_addr),
      .wr_data (cmd.push_rem ? rem_addr_ff : addr_ff),
      .rd_en   (cmd.pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      resv_in     = resv_ff;
      mode_in     = mode_ff;
      n_in        = n_ff;
      addr_in     = addr_ff;
      bump_in     = bump_ff;
      rem_addr_in = rem_addr_ff;
      rem_size_in = rem_size_ff;
      cnt_in      = cnt_ff;
      off_in      = off_ff;
      frames_in   = frames_ff;
      found_in    = found_ff;
      rel_in      = rel_ff;
      res_addr_in = res_addr_ff;
      res_size_in = res_size_ff;
      res_stat_in = res_stat_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_PART_START: begin
               start_in = csr_wdata;
               bump_in  = csr_wdata;
            end
            CSR_PART_END: end_in  = csr_wdata;
            CSR_RESERVE:  resv_in = csr_wdata[RESV_W-1:0];
            default: ;
         endcase
      end

      if (req_valid && !req_stall) begin
         mode_in = req_mode;
         n_in    = req_request_size;
         addr_in = req_block_address;
      end

      if (cmd.eval) begin
         found_in    = found_idx;
         res_addr_in = '0;
         res_size_in = '0;
         res_stat_in = STAT_OK;
      end

      if (cmd.free_push && push_fail) res_stat_in = STAT_NO_FRAME;

      if (cmd.take_rem) begin
         res_addr_in = rem_addr_ff;
         if ({1'b0, rem_size_ff} >= ({1'b0, n_w} + (W + 1)'(2))) begin
            res_size_in = n_ff;
            rem_addr_in = rem_addr_ff + ADDR_W'(n_ff);
            rem_size_in = rem_size_ff - n_w;
         end else begin
            res_size_in = rem_size_ff[SIZE_W-1:0];
            rem_addr_in = '0;
            rem_size_in = '0;
         end
      end

      if (cmd.take_bump) begin
         res_addr_in = bump_ff;
         res_size_in = n_ff;
         bump_in     = bump_n_sum[ADDR_W] ? '1 : bump_n_sum[ADDR_W-1:0];
      end

      if (cmd.oom) res_stat_in = STAT_OOM;

      if (cmd.pop) begin
         cnt_in[sel] = cnt_sel - CNT_W'(1);
         off_in[sel] = off_dec;
         rel_in      = off_dec == '0;
         res_size_in = stat.split ? n_ff : found_w[SIZE_W-1:0];
      end

      if (cmd.pop_data) res_addr_in = rd_data;

      if (push_write) begin
         cnt_in[sel] = cnt_sel + CNT_W'(1);
         off_in[sel] = (off_sel == OFF_TOP) ? '0 : off_sel + OFF_W'(1);
      end

      if (cmd.push_rem && push_fail) res_stat_in = STAT_NO_FRAME;

      if (new_rem) begin
         rem_addr_in = rem_src + ADDR_W'(n_ff);
         rem_size_in = found_w - n_w;
      end

      frames_in = frames_ff - FR_W'(push_write && need_frame) +
                  FR_W'(release_now && rel_ff);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in  = rsp_addr_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = res_addr_ff;
         rsp_size_in  = res_size_ff;
         rsp_stat_in  = res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= RESET_PART_START;
         end_ff       <= RESET_PART_END;
         resv_ff      <= RESET_RESERVE;
         bump_ff      <= RESET_PART_START;
         rem_addr_ff  <= '0;
         rem_size_ff  <= '0;
         frames_ff    <= FR_W'(FRAMES);
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < SIZE_CLASSES; c++) begin
            cnt_ff[c] <= '0;
            off_ff[c] <= '0;
         end
      end else begin
         start_ff     <= start_in;
         end_ff       <= end_in;
         resv_ff      <= resv_in;
         bump_ff      <= bump_in;
         rem_addr_ff  <= rem_addr_in;
         rem_size_ff  <= rem_size_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         off_ff       <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      n_ff        <= n_in;
      addr_ff     <= addr_in;
      found_ff    <= found_in;
      rel_ff      <= rel_in;
      res_addr_ff <= res_addr_in;
      res_size_ff <= res_size_in;
      res_stat_ff <= res_stat_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_size_ff <= rsp_size_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_granted_size    = rsp_size_ff;
   assign rsp_status          = rsp_stat_ff;

   `SBA_ASSERT(a_rem_never_one, clock, reset, rem_size_ff != W'(1))
   `SBA_ASSERT(a_frames_bound, clock, reset, frames_ff <= FR_W'(FRAMES))
   `SBA_ASSERT_IMPL(a_pop_nonempty, clock, reset, cmd.pop, cnt_sel != '0)

endmodule

// File: hdl/size_class_block_allocator.sv
// Block allocator for one partition with per-size free stacks.
// Request channel (req_): mode 0 allocates req_request_size blocks, mode 1
// frees the run at req_block_address onto the stack of its size. A request
// transfers when req_valid is high and req_stall is low.
// Result channel (rsp_): one result per request with the granted address,
// granted size and status (ok, out of memory, out of free frames).
// Config channel (csr_): partition start, partition end, reserve margin;
// csr_ready is always high. Writing the start also reloads the bump pointer.
// Timing: one request at a time. A free, a remainder or a bump grant and an
// out-of-memory result pass from the evaluate state straight to the result
// state; a grant from a class stack passes through a stack read state, a read
// data state and, when the old remainder is pushed back, a split state, set by
// the stack memory's registered read followed by its single write port. The
// next request can transfer once its predecessor's result is in the output register.
// Reset: bump pointer at partition start, all stacks empty, all frames free.
// A stalled result holds in the output register; the next request is still
// taken, but its result waits until the held one has transferred.
module size_class_block_allocator import sba_pkg::*; #(
   parameter int SIZE_CLASSES      = DEF_SIZE_CLASSES,
   parameter int ENTRIES_PER_FRAME = DEF_ENTRIES_PER_FRAME,
   parameter int FRAMES            = DEF_FRAMES,
   parameter int CLASS_DEPTH       = DEF_CLASS_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_mode,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [ADDR_W-1:0]    req_block_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ADDR_W-1:0]    rsp_granted_address,
   output logic [SIZE_W-1:0]    rsp_granted_size,
   output logic [STAT_W-1:0]    rsp_status,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   sba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sba_datapath #(
      .SIZE_CLASSES      (SIZE_CLASSES),
      .ENTRIES_PER_FRAME (ENTRIES_PER_FRAME),
      .FRAMES            (FRAMES),
      .CLASS_DEPTH       (CLASS_DEPTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted_address (rsp_granted_address),
      .rsp_granted_size    (rsp_granted_size),
      .rsp_status          (rsp_status),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd                 (cmd),
      .stat                (stat)
   );

endmodule
